// ===== rtl/core/msed_pkg.sv =====
// Shared types, register indexes and constants of the sensor event detector.
`timescale 1ns / 1ps

package msed_pkg;

  // Fixed field widths.
  localparam int THR_W      = 24;
  localparam int SUM_W      = 29;
  localparam int RISE_W     = 25;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MODE_W     = 3;
  localparam int WSIZE_W    = 5;
  localparam int SENS_W     = 4;
  localparam int GAS_W      = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WSIZE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_THR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAS_KIND  = 3'd5;

  // Detection modes; the two unused codes act as a plain threshold.
  localparam logic [MODE_W-1:0] MODE_SIMPLE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_AVG    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RATE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SMOKE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GAS    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MOTION = 3'd5;

  // Gas kinds.
  localparam logic [GAS_W-1:0] GAS_CO      = 3'd0;
  localparam logic [GAS_W-1:0] GAS_LPG     = 3'd1;
  localparam logic [GAS_W-1:0] GAS_METHANE = 3'd2;
  localparam logic [GAS_W-1:0] GAS_NATURAL = 3'd3;

  // Operations carried by a request.
  localparam logic OP_EVAL  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Register reset values.
  localparam logic signed [THR_W-1:0] THRESHOLD_RST = 24'sd12800;
  localparam logic signed [THR_W-1:0] RATE_THR_RST  = 24'sd1280;
  localparam logic [WSIZE_W-1:0]      WSIZE_RST     = 5'd5;
  localparam logic [SENS_W-1:0]       SENS_RST      = 4'd5;
  localparam logic [SENS_W-1:0]       SENS_MIN      = 4'd1;
  localparam logic [SENS_W-1:0]       SENS_MAX      = 4'd10;

  // Smoke and motion scale bases.
  localparam logic [4:0] SMOKE_BASE = 5'd29;
  localparam logic [3:0] MOTION_BASE = 4'd15;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [THR_W-1:0]   threshold;
    logic [WSIZE_W-1:0]        window_size;
    logic signed [THR_W-1:0]   rate_threshold;
    logic [SENS_W-1:0]         sensitivity;
    logic [GAS_W-1:0]          gas_kind;
  } cfg_t;

  // Pipeline strobes: a request enters, and the evaluate stage moves on.
  typedef struct packed {
    logic acc;
    logic adv;
  } pipe_ctl_t;

  // Default threshold per gas kind, Q16.8.
  function automatic logic signed [THR_W-1:0] gas_default(logic [GAS_W-1:0] kind);
    logic signed [THR_W-1:0] val;
    case (kind)
      GAS_CO:      val = 24'sd12800;
      GAS_LPG:     val = 24'sd256000;
      GAS_METHANE: val = 24'sd1280000;
      GAS_NATURAL: val = 24'sd640000;
      default:     val = 24'sd256000;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/core/msed_cfg.sv =====
// Configuration register bank of the sensor event detector.
`timescale 1ns / 1ps

module msed_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [msed_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [msed_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output msed_pkg::cfg_t                      cfg_o
);
  import msed_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the register index and replace the addressed field.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:      cfg_d.mode           = cfg_wdata_i[MODE_W-1:0];
        CFG_THRESHOLD: cfg_d.threshold      = $signed(cfg_wdata_i[THR_W-1:0]);
        CFG_WSIZE:     cfg_d.window_size    = cfg_wdata_i[WSIZE_W-1:0];
        CFG_RATE_THR:  cfg_d.rate_threshold = $signed(cfg_wdata_i[THR_W-1:0]);
        CFG_SENS:      cfg_d.sensitivity    = cfg_wdata_i[SENS_W-1:0];
        CFG_GAS_KIND:  cfg_d.gas_kind       = cfg_wdata_i[GAS_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode           <= MODE_SIMPLE;
      cfg_q.threshold      <= THRESHOLD_RST;
      cfg_q.window_size    <= WSIZE_RST;
      cfg_q.rate_threshold <= RATE_THR_RST;
      cfg_q.sensitivity    <= SENS_RST;
      cfg_q.gas_kind       <= GAS_CO;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/msed_window.sv =====
// Sample history: window memory, write slot, fill count, previous sample and running sum.
`timescale 1ns / 1ps

module msed_window #(
  parameter int MAX_WINDOW  = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  msed_pkg::pipe_ctl_t                    ctl_i,
  input  logic                                   op_clear_i,
  input  logic signed [SAMPLE_BITS-1:0]          sample_i,
  input  logic [msed_pkg::WSIZE_W-1:0]           window_size_i,
  output logic [$clog2(MAX_WINDOW+1)-1:0]        fill_next_o,
  output logic signed [SAMPLE_BITS:0]            rise_o,
  output logic signed [msed_pkg::SUM_W-1:0]      sum_next_o
);
  import msed_pkg::*;

  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];

  logic [FILL_W-1:0]             fill_q, fill_d;
  logic [SLOT_W-1:0]             slot_q, slot_d;
  logic signed [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic signed [SUM_W-1:0]       sum_q;

  // Evaluate-stage copies taken when a request enters.
  logic signed [SAMPLE_BITS-1:0] rd_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic                          s1_full_q;
  logic                          s1_clr_q;

  logic [FILL_W-1:0] w_eff;
  logic [FILL_W-1:0] slot_inc;
  logic              full;

  // Effective window size, clamped to one through the memory depth.
  always_comb begin
    if (window_size_i == '0) begin
      w_eff = FILL_W'(1);
    end else if (32'(window_size_i) > MAX_WINDOW) begin
      w_eff = FILL_W'(MAX_WINDOW);
    end else begin
      w_eff = FILL_W'(window_size_i);
    end
  end

  // Next fill count, write slot and previous sample.
  always_comb begin
    full     = (fill_q >= w_eff);
    slot_inc = FILL_W'(slot_q) + FILL_W'(1);
    if (op_clear_i) begin
      fill_d = '0;
      slot_d = '0;
      prev_d = '0;
    end else begin
      fill_d = full ? fill_q : fill_q + FILL_W'(1);
      slot_d = (slot_inc >= w_eff) ? '0 : SLOT_W'(slot_inc);
      prev_d = sample_i;
    end
  end

  assign fill_next_o = fill_d;
  assign rise_o      = (SAMPLE_BITS+1)'(sample_i) - (SAMPLE_BITS+1)'(prev_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      slot_q <= '0;
      prev_q <= '0;
    end else if (ctl_i.acc) begin
      fill_q <= fill_d;
      slot_q <= slot_d;
      prev_q <= prev_d;
    end
  end

  // Read-first port: the old entry is read while the new sample replaces it,
  // so back-to-back requests to the same slot need no forwarding.
  always_ff @(posedge clk_i) begin
    if (ctl_i.acc) begin
      rd_q <= mem[slot_q];
      if (!op_clear_i) begin
        mem[slot_q] <= sample_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc) begin
      s1_sample_q <= sample_i;
      s1_full_q   <= full;
      s1_clr_q    <= op_clear_i;
    end
  end

  // Running sum: drop the evicted entry once the window is full, add the new sample.
  always_comb begin
    if (s1_clr_q) begin
      sum_next_o = '0;
    end else if (s1_full_q) begin
      sum_next_o = sum_q - SUM_W'(rd_q) + SUM_W'(s1_sample_q);
    end else begin
      sum_next_o = sum_q + SUM_W'(s1_sample_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctl_i.adv) begin
      sum_q <= sum_next_o;
    end
  end

endmodule

// ===== rtl/core/msed_eval.sv =====
// Mode evaluation: scaled operands on entry, final compare in the evaluate stage.
`timescale 1ns / 1ps

module msed_eval #(
  parameter int MAX_WINDOW  = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                   clk_i,
  input  msed_pkg::pipe_ctl_t                    ctl_i,
  input  msed_pkg::cfg_t                         cfg_i,
  input  logic                                   op_clear_i,
  input  logic signed [SAMPLE_BITS-1:0]          sample_i,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]        fill_next_i,
  input  logic signed [SAMPLE_BITS:0]            rise_i,
  input  logic signed [msed_pkg::SUM_W-1:0]      sum_next_i,
  output logic                                   detected_o,
  output logic signed [msed_pkg::RISE_W-1:0]     rise_o,
  output logic [$clog2(MAX_WINDOW+1)-1:0]        fill_o
);
  import msed_pkg::*;

  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int CW     = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 9;

  logic signed [CW-1:0]        s_x, t_x;
  logic [SENS_W-1:0]           k;
  logic [4:0]                  f_smoke;
  logic [3:0]                  f_motion;
  logic signed [THR_W+5:0]     smoke_p;
  logic signed [THR_W+4:0]     motion_p;
  logic signed [THR_W+FILL_W:0] avg_p;
  logic signed [THR_W-1:0]     gas_thr;
  logic signed [CW-1:0]        lhs_d, rhs_d;
  logic                        avg_d, gate_d;

  logic signed [CW-1:0]        lhs_q, rhs_q;
  logic                        avg_q, gate_q, clr_q;
  logic signed [RISE_W-1:0]    rise_q;
  logic [FILL_W-1:0]           fill_q;

  // Sensitivity clamp and the scale factors for smoke and motion.
  always_comb begin
    if (cfg_i.sensitivity < SENS_MIN) begin
      k = SENS_MIN;
    end else if (cfg_i.sensitivity > SENS_MAX) begin
      k = SENS_MAX;
    end else begin
      k = cfg_i.sensitivity;
    end
    f_smoke  = SMOKE_BASE - {k, 1'b0};
    f_motion = MOTION_BASE - k;
  end

  // Narrow multiplies for the scaled modes; the mode picks the pair to compare later.
  always_comb begin
    s_x      = CW'(sample_i);
    t_x      = CW'(cfg_i.threshold);
    smoke_p  = cfg_i.threshold * $signed({1'b0, f_smoke});
    motion_p = cfg_i.threshold * $signed({1'b0, f_motion});
    avg_p    = cfg_i.threshold * $signed({1'b0, fill_next_i});
    gas_thr  = (cfg_i.threshold <= 0) ? gas_default(cfg_i.gas_kind) : cfg_i.threshold;
    avg_d    = 1'b0;
    gate_d   = 1'b1;
    case (cfg_i.mode)
      MODE_AVG: begin
        lhs_d = '0;
        rhs_d = CW'(avg_p);
        avg_d = 1'b1;
      end
      MODE_RATE: begin
        lhs_d  = s_x;
        rhs_d  = t_x;
        gate_d = (CW'(rise_i) > CW'(cfg_i.rate_threshold));
      end
      MODE_SMOKE: begin
        lhs_d = CW'(s_x * 18);
        rhs_d = CW'(smoke_p);
      end
      MODE_GAS: begin
        lhs_d = s_x;
        rhs_d = CW'(gas_thr);
      end
      MODE_MOTION: begin
        lhs_d = CW'(s_x * 5);
        rhs_d = CW'(motion_p);
      end
      default: begin
        lhs_d = s_x;
        rhs_d = t_x;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc) begin
      lhs_q  <= lhs_d;
      rhs_q  <= rhs_d;
      avg_q  <= avg_d;
      gate_q <= gate_d;
      clr_q  <= op_clear_i;
      rise_q <= op_clear_i ? '0 : RISE_W'(rise_i);
      fill_q <= fill_next_i;
    end
  end

  // Final compare; averaging uses the running sum that this stage produces.
  always_comb begin
    if (clr_q) begin
      detected_o = 1'b0;
    end else if (avg_q) begin
      detected_o = (CW'(sum_next_i) > rhs_q);
    end else begin
      detected_o = (lhs_q > rhs_q) && gate_q;
    end
  end

  assign rise_o = rise_q;
  assign fill_o = fill_q;

endmodule

// ===== rtl/core/multi_mode_sensor_event_detector_unit.sv =====
// Top level of the multi-mode sensor event detector.
//
// Requests arrive on in_valid_i/in_ready_o with operation_i and sample_i;
// results leave on out_valid_o/out_ready_i with detected_o, rise_o and
// window_fill_o, one result per request, in order. Configuration registers
// are written through cfg_we_i/cfg_idx_i/cfg_wdata_i, one register per cycle;
// the user must write them only while no request is in flight, and the block
// itself does not enforce this. Throughput is one request per cycle while the
// output is not stalled. An accepted request passes the evaluate-stage
// registers, which capture the window memory read from a read-first port that
// returns the evicted entry as the new sample is written, then the output
// register, which loads the running-sum update and final compare.
// Reset returns the registers to their defaults, empties the history and
// drops both valids; the window memory needs no clearing pass because the
// fill count guards every read. When the receiver stalls, the output
// register holds its result, one more request waits in the evaluate stage,
// and in_ready_o falls until the output is taken.
`timescale 1ns / 1ps

module multi_mode_sensor_event_detector_unit #(
  parameter int MAX_WINDOW  = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [msed_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [msed_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 operation_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 detected_o,
  output logic signed [msed_pkg::RISE_W-1:0]   rise_o,
  output logic [$clog2(MAX_WINDOW+1)-1:0]      window_fill_o
);
  import msed_pkg::*;

  localparam int FILL_W = $clog2(MAX_WINDOW + 1);

  cfg_t      cfg;
  pipe_ctl_t ctl;
  logic      op_clear;
  logic      s1_valid_q, s1_valid_d;
  logic      out_valid_q, out_valid_d;
  logic      can_adv;

  logic [FILL_W-1:0]             fill_next;
  logic signed [SAMPLE_BITS:0]   rise_in;
  logic signed [SUM_W-1:0]       sum_next;
  logic                          det_s1;
  logic signed [RISE_W-1:0]      rise_s1;
  logic [FILL_W-1:0]             fill_s1;

  logic                          detected_q;
  logic signed [RISE_W-1:0]      rise_q;
  logic [FILL_W-1:0]             fill_q;

  // Handshake: the evaluate stage moves on whenever the output register frees up.
  always_comb begin
    op_clear    = (operation_i == OP_CLEAR);
    can_adv     = !out_valid_q || out_ready_i;
    in_ready_o  = !s1_valid_q || can_adv;
    ctl.acc     = in_valid_i && in_ready_o;
    ctl.adv     = s1_valid_q && can_adv;
    s1_valid_d  = ctl.acc ? 1'b1 : (ctl.adv ? 1'b0 : s1_valid_q);
    out_valid_d = ctl.adv ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  msed_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  msed_window #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .op_clear_i    (op_clear),
    .sample_i      (sample_i),
    .window_size_i (cfg.window_size),
    .fill_next_o   (fill_next),
    .rise_o        (rise_in),
    .sum_next_o    (sum_next)
  );

  msed_eval #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_eval (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .cfg_i       (cfg),
    .op_clear_i  (op_clear),
    .sample_i    (sample_i),
    .fill_next_i (fill_next),
    .rise_i      (rise_in),
    .sum_next_i  (sum_next),
    .detected_o  (det_s1),
    .rise_o      (rise_s1),
    .fill_o      (fill_s1)
  );

  // Output register.
  always_ff @(posedge clk_i) begin
    if (ctl.adv) begin
      detected_q <= det_s1;
      rise_q     <= rise_s1;
      fill_q     <= fill_s1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign detected_o    = detected_q;
  assign rise_o        = rise_q;
  assign window_fill_o = fill_q;

endmodule

// ===== rtl/core/msed_checker.sv =====
// Port-level checks of the sensor event detector and their binding to the top level.
`timescale 1ns / 1ps

module msed_checker #(
  parameter int MAX_WINDOW  = 16,
  parameter int SAMPLE_BITS = 24
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 cfg_we_i,
  input logic [msed_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input logic [msed_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 operation_i,
  input logic signed [SAMPLE_BITS-1:0]        sample_i,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic                                 detected_o,
  input logic signed [msed_pkg::RISE_W-1:0]   rise_o,
  input logic [$clog2(MAX_WINDOW+1)-1:0]      window_fill_o
);
  import msed_pkg::*;

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(detected_o) && $stable(rise_o) && $stable(window_fill_o))
    else $error("result changed while stalled");

  // Requests are refused only while a result is waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("request refused with an empty output");

  // Only a clear leaves the window empty, and its result is all zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (window_fill_o == '0) |-> !detected_o && (rise_o == '0))
    else $error("empty window with a nonzero result");

  // The fill count never exceeds the window depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(window_fill_o) <= MAX_WINDOW))
    else $error("window fill beyond depth");

endmodule

bind multi_mode_sensor_event_detector_unit msed_checker #(
  .MAX_WINDOW  (MAX_WINDOW),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_msed_checker (.*);
